// ===== hdl/qlind_pkg.sv =====
// ----------------------------------------------------------------------------
// qlind_pkg: shared types and constants for the qubit Lindblad Euler step
// Fixed-point widths, register indexes, channel payloads and saturation.
// ----------------------------------------------------------------------------
package qlind_pkg;

   localparam int RHO_FRAC_BITS = 30;
   localparam int RHO_W         = 32;
   localparam int FIX_W         = 48;
   localparam int OPW           = 64;
   localparam int ACC_W         = 112;
   localparam int HALF_W        = 32;
   localparam int DERIV_SHIFT   = 25;
   localparam int DT_SHIFT      = 48;
   localparam int CSR_IDX_W     = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELAX_RATE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPHASE_RATE = 2'd2;

   typedef struct packed {
      logic signed [FIX_W-1:0] h00_re;
      logic signed [FIX_W-1:0] h00_im;
      logic signed [FIX_W-1:0] h01_re;
      logic signed [FIX_W-1:0] h01_im;
      logic signed [FIX_W-1:0] h10_re;
      logic signed [FIX_W-1:0] h10_im;
      logic signed [FIX_W-1:0] h11_re;
      logic signed [FIX_W-1:0] h11_im;
   } req_type;

   typedef struct packed {
      logic signed [RHO_W-1:0] pop_ground;
      logic signed [RHO_W-1:0] pop_excited;
      logic signed [RHO_W-1:0] coherence_re;
      logic signed [RHO_W-1:0] coherence_im;
      logic signed [RHO_W-1:0] sz_expectation;
   } rsp_type;

   typedef struct packed {
      logic       issue;
      logic       clear;
      logic [1:0] half;
   } mac_ctl_type;

   function automatic logic signed [RHO_W-1:0] sat_rho(input logic signed [OPW:0] v);
      logic signed [OPW:0] hi;
      logic signed [OPW:0] lo;
      hi = (OPW+1)'({1'b0, {(RHO_W-1){1'b1}}});
      lo = -hi - (OPW+1)'(1);
      if (v > hi) begin
         sat_rho = hi[RHO_W-1:0];
      end else if (v < lo) begin
         sat_rho = lo[RHO_W-1:0];
      end else begin
         sat_rho = v[RHO_W-1:0];
      end
   endfunction

endpackage

// ===== hdl/qubit_lindblad_euler_step.sv =====
// ----------------------------------------------------------------------------
// qubit_lindblad_euler_step: one Euler step of the two-level Lindblad equation
// Keeps a qubit density matrix and advances it once per Hamiltonian item.
// ----------------------------------------------------------------------------
// Usage: software writes the time step and the two rates through the csr_
// port while the block is idle; csr_ready is always high. Each item on the
// req_ channel carries one complex 2x2 Hamiltonian and produces exactly one
// item on the rsp_ channel with the new populations, coherence and <sigma_z>.
// The block works on one item at a time and holds req_stall high from the
// cycle after acceptance until the result is loaded into the output
// register. Each item takes three derivative passes, whose length is set
// by the single 32x32 multiplier that forms every product as four partial
// products; then ST_FIN updates the state and ST_OUT loads the output. The
// next item is taken in the cycle after the result is loaded, even while
// that result still waits, so a new item is never taken before the last
// one is through. If the receiver stalls, the result holds in the output
// register and the block waits before loading a newer one. Reset clears
// the rates and the step size and returns the matrix to the ground state.
// ----------------------------------------------------------------------------
module qubit_lindblad_euler_step (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  qlind_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output qlind_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [qlind_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [qlind_pkg::FIX_W-1:0]           csr_data
);
   import qlind_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   localparam logic [4:0] CYC_DRAIN1 = 5'd12;
   localparam logic [4:0] CYC_RATE   = 5'd13;
   localparam logic [4:0] CYC_DT0    = 5'd14;
   localparam logic [4:0] CYC_DRAIN2 = 5'd18;
   localparam logic [4:0] CYC_INC    = 5'd19;

   logic [1:0]              state_ff, state_in;
   logic [4:0]              cyc_ff, cyc_in;
   logic [1:0]              term_ff, term_in;
   logic [FIX_W-1:0]        step_ff, relax_ff, dephase_ff;
   logic signed [RHO_W-1:0] a_ff, b_ff, cr_ff, ci_ff;
   logic signed [RHO_W-1:0] a_in, b_in, cr_in, ci_in;
   logic signed [FIX_W:0]   pr_ff, pi_ff, e_ff;
   logic signed [OPW-1:0]   rate_ff;
   logic signed [OPW-1:0]   inc_a_ff, inc_cr_ff, inc_ci_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic signed [OPW-1:0]   a64, b64, cr64, ci64, d64, pr64, pi64, e64;
   logic signed [OPW-1:0]   g1_64, gc64, dt64;
   logic signed [OPW-1:0]   op_x, op_y;
   logic [1:0]              op_sel;
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] rnd_rate, rnd_inc;
   logic                    accept;
   mac_ctl_type             ctl;

   qlind_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .op_x  (op_x),
      .op_y  (op_y),
      .acc   (acc)
   );

   assign accept    = req_valid & ~req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      a64   = OPW'(a_ff);
      b64   = OPW'(b_ff);
      cr64  = OPW'(cr_ff);
      ci64  = OPW'(ci_ff);
      d64   = a64 - b64;
      pr64  = OPW'(pr_ff);
      pi64  = OPW'(pi_ff);
      e64   = OPW'(e_ff);
      g1_64 = $signed(OPW'(relax_ff));
      dt64  = $signed(OPW'(step_ff));
      gc64  = g1_64 + ($signed(OPW'(dephase_ff)) <<< 2);
   end

   always_comb begin
      op_sel = (cyc_ff < CYC_DRAIN1) ? cyc_ff[3:2] : 2'd3;
      op_x   = rate_ff;
      op_y   = dt64;
      unique case ({term_ff, op_sel})
         4'b00_00: begin op_x = cr64 <<< 1;    op_y = pi64;  end
         4'b00_01: begin op_x = -(ci64 <<< 1); op_y = pr64;  end
         4'b00_10: begin op_x = -(a64 <<< 1);  op_y = g1_64; end
         4'b01_00: begin op_x = e64 <<< 1;     op_y = ci64;  end
         4'b01_01: begin op_x = -d64;          op_y = pi64;  end
         4'b01_10: begin op_x = -cr64;         op_y = gc64;  end
         4'b10_00: begin op_x = d64;           op_y = pr64;  end
         4'b10_01: begin op_x = -(e64 <<< 1);  op_y = cr64;  end
         4'b10_10: begin op_x = -ci64;         op_y = gc64;  end
         default: begin op_x = rate_ff;        op_y = dt64;  end
      endcase
   end

   always_comb begin
      ctl.issue = (state_ff == ST_RUN) &&
                  ((cyc_ff < CYC_DRAIN1) || ((cyc_ff >= CYC_DT0) && (cyc_ff < CYC_DRAIN2)));
      ctl.clear = accept || ((state_ff == ST_RUN) &&
                  ((cyc_ff == CYC_RATE) || (cyc_ff == CYC_INC)));
      ctl.half  = (cyc_ff < CYC_DRAIN1) ? cyc_ff[1:0] : 2'(cyc_ff + 5'd2);
      rnd_rate  = acc + (ACC_W'(1) <<< (DERIV_SHIFT-1));
      rnd_inc   = acc + (ACC_W'(1) <<< (DT_SHIFT-1));
   end

   always_comb begin
      state_in     = state_ff;
      cyc_in       = cyc_ff;
      term_in      = term_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               cyc_in   = '0;
               term_in  = '0;
            end
         end
         ST_RUN: begin
            if (cyc_ff == CYC_INC) begin
               cyc_in = '0;
               if (term_ff == 2'd2) begin
                  state_in = ST_FIN;
               end else begin
                  term_in = term_ff + 2'd1;
               end
            end else begin
               cyc_in = cyc_ff + 5'd1;
            end
         end
         ST_FIN: begin
            a_in     = sat_rho((OPW+1)'(a64) + (OPW+1)'(inc_a_ff));
            b_in     = sat_rho((OPW+1)'(b64) - (OPW+1)'(inc_a_ff));
            cr_in    = sat_rho((OPW+1)'(cr64) + (OPW+1)'(inc_cr_ff));
            ci_in    = sat_rho((OPW+1)'(ci64) + (OPW+1)'(inc_ci_ff));
            state_in = ST_OUT;
         end
         default: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_in.pop_ground     = a_ff;
               rsp_in.pop_excited    = b_ff;
               rsp_in.coherence_re   = cr_ff;
               rsp_in.coherence_im   = ci_ff;
               rsp_in.sz_expectation = sat_rho((OPW+1)'(a64) - (OPW+1)'(b64));
               state_in              = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cyc_ff       <= '0;
         term_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         relax_ff     <= '0;
         dephase_ff   <= '0;
         a_ff         <= RHO_W'(1) <<< RHO_FRAC_BITS;
         b_ff         <= '0;
         cr_ff        <= '0;
         ci_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         cyc_ff       <= cyc_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         cr_ff        <= cr_in;
         ci_ff        <= ci_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_STEP_SIZE:    step_ff    <= csr_data;
               CSR_RELAX_RATE:   relax_ff   <= csr_data;
               CSR_DEPHASE_RATE: dephase_ff <= csr_data;
               default: ;
            endcase
         end
      end
      rsp_ff <= rsp_in;
      if (accept) begin
         pr_ff <= (FIX_W+1)'(req_data.h01_re) + (FIX_W+1)'(req_data.h10_re);
         pi_ff <= (FIX_W+1)'(req_data.h01_im) - (FIX_W+1)'(req_data.h10_im);
         e_ff  <= (FIX_W+1)'(req_data.h00_re) - (FIX_W+1)'(req_data.h11_re);
      end
      if (state_ff == ST_RUN && cyc_ff == CYC_RATE) begin
         rate_ff <= rnd_rate[DERIV_SHIFT+OPW-1:DERIV_SHIFT];
      end
      if (state_ff == ST_RUN && cyc_ff == CYC_INC) begin
         unique case (term_ff)
            2'd0:    inc_a_ff  <= rnd_inc[ACC_W-1:DT_SHIFT];
            2'd1:    inc_cr_ff <= rnd_inc[ACC_W-1:DT_SHIFT];
            default: inc_ci_ff <= rnd_inc[ACC_W-1:DT_SHIFT];
         endcase
      end
   end

endmodule

// ===== hdl/qlind_mac.sv =====
// ----------------------------------------------------------------------------
// qlind_mac: shared multiply-accumulate unit
// Multiplies two signed operands one 32x32 partial product per cycle and
// accumulates the registered partial products with sign and alignment.
// ----------------------------------------------------------------------------
module qlind_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  qlind_pkg::mac_ctl_type            ctl,
   input  logic signed [qlind_pkg::OPW-1:0]  op_x,
   input  logic signed [qlind_pkg::OPW-1:0]  op_y,
   output logic signed [qlind_pkg::ACC_W-1:0] acc
);
   import qlind_pkg::*;

   logic [OPW-1:0]          mag_x;
   logic [OPW-1:0]          mag_y;
   logic [HALF_W-1:0]       part_x;
   logic [HALF_W-1:0]       part_y;
   logic [2*HALF_W-1:0]     pp_in;
   logic [2*HALF_W-1:0]     pp_ff;
   logic                    pend_in, pend_ff;
   logic                    neg_in, neg_ff;
   logic [1:0]              shift_in, shift_ff;
   logic signed [ACC_W-1:0] aligned;
   logic signed [ACC_W-1:0] acc_in, acc_ff;

   always_comb begin
      mag_x    = op_x[OPW-1] ? OPW'(-op_x) : OPW'(op_x);
      mag_y    = op_y[OPW-1] ? OPW'(-op_y) : OPW'(op_y);
      part_x   = ctl.half[0] ? mag_x[OPW-1:HALF_W] : mag_x[HALF_W-1:0];
      part_y   = ctl.half[1] ? mag_y[OPW-1:HALF_W] : mag_y[HALF_W-1:0];
      pp_in    = part_x * part_y;
      pend_in  = ctl.issue;
      neg_in   = op_x[OPW-1] ^ op_y[OPW-1];
      shift_in = 2'(ctl.half[0]) + 2'(ctl.half[1]);
   end

   always_comb begin
      unique case (shift_ff)
         2'd0:    aligned = $signed(ACC_W'(pp_ff));
         2'd1:    aligned = $signed(ACC_W'(pp_ff) << HALF_W);
         default: aligned = $signed(ACC_W'(pp_ff) << (2*HALF_W));
      endcase
      if (ctl.clear) begin
         acc_in = '0;
      end else if (pend_ff) begin
         acc_in = neg_ff ? acc_ff - aligned : acc_ff + aligned;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         acc_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         acc_ff  <= acc_in;
      end
      pp_ff    <= pp_in;
      neg_ff   <= neg_in;
      shift_ff <= shift_in;
   end

   assign acc = acc_ff;

endmodule

// ===== tb/tb_qubit_lindblad_euler_step.sv =====
// ----------------------------------------------------------------------------
// tb_qubit_lindblad_euler_step: self-checking bench for the Lindblad Euler step
// Drives Hamiltonian items through several rate and step settings, predicts
// each updated density matrix in wide fixed point and checks every result.
// ----------------------------------------------------------------------------
module tb_qubit_lindblad_euler_step;
   import qlind_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [FIX_W-1:0] csr_data = '0;

   qubit_lindblad_euler_step dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   req_type hamiltonian_q[$];
   rsp_type density_q[$];
   logic [FIX_W-1:0] dt_reg, relax_reg, dephase_reg;
   longint rho_ground, rho_excited, rho_cre, rho_cim;
   int mismatches = 0;
   int rsp_count = 0;
   int send_gap = 0;
   int hold_cnt = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit long_hold_done = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint round_shift(logic signed [127:0] x, int k);
      logic signed [127:0] t;
      t = (x + (128'sd1 <<< (k - 1))) >>> k;
      if (t[127:63] != {65{t[127]}}) begin
         return t[127] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      end
      return t[63:0];
   endfunction

   function automatic logic signed [127:0] wmul(longint a, longint b);
      logic signed [127:0] x, y;
      x = 128'(a);
      y = 128'(b);
      return x * y;
   endfunction

   function automatic longint scale_by_dt(logic signed [127:0] deriv);
      longint rate;
      rate = round_shift(deriv, DERIV_SHIFT);
      return round_shift(wmul(rate, longint'({16'd0, dt_reg})), DT_SHIFT);
   endfunction

   function automatic longint sat32(logic signed [65:0] v);
      if (v > 66'sd2147483647) return 64'sd2147483647;
      if (v < -66'sd2147483648) return -64'sd2147483648;
      return longint'(v);
   endfunction

   function automatic void predict_step(req_type h);
      longint a, b, cr, ci, pr, pim, e, d, g1, gc, inc_a, inc_cr, inc_ci;
      logic signed [127:0] da, dcr, dci;
      logic signed [65:0] s;
      rsp_type r;
      a = rho_ground;
      b = rho_excited;
      cr = rho_cre;
      ci = rho_cim;
      pr = longint'(h.h01_re) + longint'(h.h10_re);
      pim = longint'(h.h01_im) - longint'(h.h10_im);
      e = longint'(h.h00_re) - longint'(h.h11_re);
      d = a - b;
      g1 = longint'({16'd0, relax_reg});
      gc = g1 + 4 * longint'({16'd0, dephase_reg});
      da = wmul(2 * cr, pim) + wmul(-2 * ci, pr) + wmul(-2 * a, g1);
      dcr = wmul(2 * e, ci) + wmul(-d, pim) + wmul(-cr, gc);
      dci = wmul(d, pr) + wmul(-2 * e, cr) + wmul(-ci, gc);
      inc_a = scale_by_dt(da);
      inc_cr = scale_by_dt(dcr);
      inc_ci = scale_by_dt(dci);
      s = 66'(a); s = s + 66'(inc_a); rho_ground = sat32(s);
      s = 66'(b); s = s - 66'(inc_a); rho_excited = sat32(s);
      s = 66'(cr); s = s + 66'(inc_cr); rho_cre = sat32(s);
      s = 66'(ci); s = s + 66'(inc_ci); rho_cim = sat32(s);
      s = 66'(rho_ground); s = s - 66'(rho_excited);
      r.pop_ground = rho_ground[31:0];
      r.pop_excited = rho_excited[31:0];
      r.coherence_re = rho_cre[31:0];
      r.coherence_im = rho_cim[31:0];
      r.sz_expectation = 32'(sat32(s));
      density_q.push_back(r);
   endfunction

   function automatic logic [FIX_W-1:0] rand_fix();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return FIX_W'({$urandom, $urandom});
      if (sel == 1) begin
         case ($urandom_range(0, 2))
            0: return 48'h7fff_ffff_ffff;
            1: return 48'h8000_0000_0000;
            default: return '0;
         endcase
      end
      return 48'(longint'($urandom_range(0, 1 << 26)) - (longint'(1) << 25));
   endfunction

   function automatic req_type rand_ham();
      req_type h;
      h.h00_re = rand_fix(); h.h00_im = rand_fix();
      h.h01_re = rand_fix(); h.h01_im = rand_fix();
      h.h10_re = rand_fix(); h.h10_im = rand_fix();
      h.h11_re = rand_fix(); h.h11_im = rand_fix();
      return h;
   endfunction

   function automatic req_type uniform_ham(logic [FIX_W-1:0] v);
      return {8{v}};
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [FIX_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_STEP_SIZE: dt_reg = val;
         CSR_RELAX_RATE: relax_reg = val;
         CSR_DEPHASE_RATE: dephase_reg = val;
         default: ;
      endcase
   endtask

   task automatic set_rates(logic [FIX_W-1:0] dt, logic [FIX_W-1:0] g1,
                            logic [FIX_W-1:0] gp);
      write_csr(CSR_STEP_SIZE, dt);
      write_csr(CSR_RELAX_RATE, g1);
      write_csr(CSR_DEPHASE_RATE, gp);
   endtask

   task automatic drain();
      do @(posedge clock); while (hamiltonian_q.size() != 0 || req_valid
                                  || density_q.size() != 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic load_directed();
      req_type h;
      hamiltonian_q.push_back('0);
      hamiltonian_q.push_back(uniform_ham(48'h7fff_ffff_ffff));
      hamiltonian_q.push_back(uniform_ham(48'h8000_0000_0000));
      hamiltonian_q.push_back(uniform_ham(48'hffff_ffff_ffff));
      h = '0; h.h01_re = 48'd1 << 24; h.h10_re = 48'd1 << 24;
      hamiltonian_q.push_back(h);
      h = '0; h.h01_im = -(48'd1 << 24); h.h10_im = 48'd1 << 24;
      hamiltonian_q.push_back(h);
      h = '0; h.h00_re = 48'd1 << 24; h.h11_re = -(48'd1 << 24);
      hamiltonian_q.push_back(h);
      h = '0; h.h00_im = 48'h7fff_ffff_ffff; h.h11_im = 48'h8000_0000_0000;
      hamiltonian_q.push_back(h);
      h = '0; h.h01_re = 48'd3 << 22; h.h10_im = 48'd5 << 21;
      hamiltonian_q.push_back(h);
      h = uniform_ham(48'h5555_5555_5555); h.h01_im = 48'haaaa_aaaa_aaaa;
      hamiltonian_q.push_back(h);
      h = uniform_ham(48'haaaa_aaaa_aaaa);
      hamiltonian_q.push_back(h);
   endtask

   task automatic run_random(int n);
      repeat (n) hamiltonian_q.push_back(rand_ham());
      drain();
   endtask

   always @(posedge clock) begin
      logic nv;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nv = req_valid;
         if (req_valid && !req_stall) begin
            predict_step(req_data);
            nv = 1'b0;
         end
         if (!nv) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
            end else if (hamiltonian_q.size() != 0) begin
               req_data <= hamiltonian_q.pop_front();
               nv = 1'b1;
               send_gap <= rand_gap();
            end
         end
         req_valid <= nv;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      int next_hold;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count <= rsp_count + 1;
            if (density_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result item %p", rsp_data);
            end else begin
               want = density_q.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result %0d mismatch: expected %p actual %p",
                              rsp_count, want, rsp_data);
                  end
               end
            end
         end
         if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
         end else begin
            if (rsp_count >= 150 && !long_hold_done) begin
               next_hold = 400;
               long_hold_done = 1'b1;
            end else begin
               next_hold = rand_gap();
            end
            hold_cnt <= next_hold;
            rsp_stall <= (next_hold != 0);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= 20000) begin
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      dt_reg = '0;
      relax_reg = '0;
      dephase_reg = '0;
      rho_ground = longint'(1) << RHO_FRAC_BITS;
      rho_excited = 0;
      rho_cre = 0;
      rho_cim = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      load_directed();
      drain();
      set_rates(48'd1 << 40, 48'd1 << 24, 48'd1 << 22);
      load_directed();
      run_random(430);
      quiet = 1'b1;
      set_rates(48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff);
      run_random(200);
      quiet = 1'b0;
      set_rates(FIX_W'({$urandom, $urandom}), FIX_W'({$urandom, $urandom}),
                FIX_W'({$urandom, $urandom}));
      run_random(430);
      set_rates(48'd1 << 36, '0, 48'hffff_ffff_ffff);
      run_random(400);
      set_rates(48'd1 << 44, 48'd2 << 24, '0);
      run_random(450);
      if (mismatches == 0 && density_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
